[rtl/dgc_pkg.sv]
package dgc_pkg;

    localparam int DIGITS_DEF    = 5;
    localparam int GAP_DEF       = 1;
    localparam int LED_COUNT_DEF = 32;

    localparam int GLYPH_W = 4;
    localparam int GLYPH_H = 6;

    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic        ok;
        logic [7:0]  text_column;
        logic [7:0]  base_led;
        logic [23:0] pixel_color;
        logic [7:0]  current_column;
    } t_ctx;

    localparam logic [23:0] FONT [10] = '{
        24'h699960, 24'h26A220, 24'h6924F0, 24'hE161E0, 24'h99F110,
        24'hF861E0, 24'h68E960, 24'hF12480, 24'h696960, 24'h697160
    };

    // Returns the six row pixels of one glyph column, row 0 in bit 0.
    function automatic logic [5:0] glyph_col(t_digit d, logic [1:0] col);
        logic [23:0] bits;
        logic [7:0]  byt;
        logic [2:0]  sh;
        logic [5:0]  m;
        bits = (d < 4'd10) ? FONT[d] : 24'd0;
        m    = '0;
        for (int r = 0; r < GLYPH_H; r++) begin
            byt  = bits[23 - 8 * (r >> 1) -: 8];
            sh   = (((r & 1) != 0) ? 3'd3 : 3'd7) - {1'b0, col};
            m[r] = byt[sh];
        end
        return m;
    endfunction

endpackage

[rtl/dgc_div10_stage.sv]
module dgc_div10_stage #(
    parameter int DIGITS = dgc_pkg::DIGITS_DEF,
    parameter int IDX    = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_value,
    input  logic [DIGITS*4-1:0]   i_digits,
    input  dgc_pkg::t_ctx         i_ctx,
    output logic                  o_valid,
    output logic [31:0]           o_quot,
    output logic [DIGITS*4-1:0]   o_digits,
    output dgc_pkg::t_ctx         o_ctx
);

    logic                r_valid;
    logic [31:0]         r_quot;
    logic [DIGITS*4-1:0] r_digits;
    dgc_pkg::t_ctx       r_ctx;

    logic [63:0]         prod;
    logic [31:0]         quot;
    logic [31:0]         rem;
    logic [DIGITS*4-1:0] n_digits;

    always_comb begin
        prod     = {32'd0, i_value} * {32'd0, dgc_pkg::RECIP10};
        quot     = {3'd0, prod[63:35]};
        rem      = i_value - ((quot << 3) + (quot << 1));
        n_digits = i_digits;
        n_digits[4*IDX +: 4] = rem[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot   <= quot;
            r_digits <= n_digits;
            r_ctx    <= i_ctx;
        end
    end

    assign o_valid  = r_valid;
    assign o_quot   = r_quot;
    assign o_digits = r_digits;
    assign o_ctx    = r_ctx;

endmodule

[rtl/dgc_render.sv]
module dgc_render #(
    parameter int DIGITS = dgc_pkg::DIGITS_DEF,
    parameter int GAP    = dgc_pkg::GAP_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_quot,
    input  logic [DIGITS*4-1:0]   i_digits,
    input  dgc_pkg::t_ctx         i_ctx,
    input  logic [7:0]            i_column_count,
    output logic                  o_valid,
    output logic                  o_drawn,
    output logic [7:0]            o_first_led,
    output logic [5:0]            o_pixel_mask,
    output logic [23:0]           o_color_out
);

    localparam int NW    = $clog2(DIGITS + 1);
    localparam int PITCH = dgc_pkg::GLYPH_W + GAP;

    // Stage A: count of digits kept after leading zeros are dropped, and a check that no quotient is left over.
    logic                r_a_valid;
    logic [NW-1:0]       r_a_n;
    logic [DIGITS*4-1:0] r_a_digits;
    dgc_pkg::t_ctx       r_a_ctx;
    logic [NW-1:0]       n_a_n;
    dgc_pkg::t_ctx       n_a_ctx;

    always_comb begin
        n_a_n = NW'(1);
        for (int j = 1; j < DIGITS; j++) begin
            if (i_digits[4*j +: 4] != 4'd0) begin
                n_a_n = NW'(j + 1);
            end
        end
        n_a_ctx    = i_ctx;
        n_a_ctx.ok = i_ctx.ok && (i_quot == 32'd0);
    end

    // Stage B: which digit glyphs cover the column, and at which glyph column.
    logic                r_b_valid;
    logic [DIGITS-1:0]   r_b_hit;
    logic [DIGITS*2-1:0] r_b_col;
    logic [DIGITS*4-1:0] r_b_digits;
    dgc_pkg::t_ctx       r_b_ctx;
    logic [DIGITS-1:0]   n_b_hit;
    logic [DIGITS*2-1:0] n_b_col;
    logic [7:0]          pos;
    logic [7:0]          start;
    logic [8:0]          stop;
    logic [7:0]          offs;

    always_comb begin
        n_b_hit = '0;
        n_b_col = '0;
        pos     = '0;
        start   = '0;
        stop    = '0;
        offs    = '0;
        for (int j = 0; j < DIGITS; j++) begin
            pos   = 8'(r_a_n) - 8'(j + 1);
            start = r_a_ctx.text_column + 8'(pos * 8'(PITCH));
            stop  = {1'b0, start} + 9'(dgc_pkg::GLYPH_W);
            offs  = r_a_ctx.current_column - start;
            n_b_hit[j] = r_a_ctx.ok && (int'(r_a_n) > j)
                && (r_a_ctx.current_column >= start)
                && ({1'b0, r_a_ctx.current_column} < stop)
                && (stop <= {1'b0, i_column_count});
            n_b_col[2*j +: 2] = offs[1:0];
        end
    end

    // Stage C: glyph lookup and merge into the output register.
    logic                r_valid;
    logic                r_drawn;
    logic [7:0]          r_first_led;
    logic [5:0]          r_pixel_mask;
    logic [23:0]         r_color_out;
    logic [5:0]          n_mask;
    logic                n_drawn;

    always_comb begin
        n_mask = '0;
        for (int j = 0; j < DIGITS; j++) begin
            if (r_b_hit[j]) begin
                n_mask = n_mask | dgc_pkg::glyph_col(r_b_digits[4*j +: 4],
                                                     r_b_col[2*j +: 2]);
            end
        end
        n_drawn = |r_b_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_valid   <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_n        <= n_a_n;
            r_a_digits   <= i_digits;
            r_a_ctx      <= n_a_ctx;
            r_b_hit      <= n_b_hit;
            r_b_col      <= n_b_col;
            r_b_digits   <= r_a_digits;
            r_b_ctx      <= r_a_ctx;
            r_drawn      <= n_drawn;
            r_first_led  <= n_drawn ? r_b_ctx.base_led : 8'd0;
            r_pixel_mask <= n_mask;
            r_color_out  <= n_drawn ? r_b_ctx.pixel_color : 24'd0;
        end
    end

    assign o_valid      = r_valid;
    assign o_drawn      = r_drawn;
    assign o_first_led  = r_first_led;
    assign o_pixel_mask = r_pixel_mask;
    assign o_color_out  = r_color_out;

endmodule

[rtl/decimal_number_glyph_column_unit.sv]
// Throughput: one transfer per cycle; one divide-by-ten stage per decimal digit,
// then three rendering stages, all advancing together while the output is free.
// Reset is synchronous and active low; it empties the pipeline and sets
// column_count to 255.
module decimal_number_glyph_column_unit #(
    parameter int DIGITS    = dgc_pkg::DIGITS_DEF,
    parameter int GAP       = dgc_pkg::GAP_DEF,
    parameter int LED_COUNT = dgc_pkg::LED_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // value[31:0], text_column[39:32], base_led[47:40], pixel_color[71:48],
    // current_column[79:72].
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // drawn[0], first_led[8:1], pixel_mask[14:9], color_out[38:15], zero[39].
    output logic [39:0] m_axis_tdata
);

    logic [7:0]          r_col_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= 8'd255;
        end else if (i_cfg_wr_en) begin
            r_col_count <= i_cfg_wr_data;
        end
    end

    logic en;
    logic out_valid;

    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    logic                r_s0_valid;
    logic [31:0]         r_s0_value;
    dgc_pkg::t_ctx       r_s0_ctx;
    dgc_pkg::t_ctx       n_s0_ctx;

    always_comb begin
        n_s0_ctx.text_column    = s_axis_tdata[39:32];
        n_s0_ctx.base_led       = s_axis_tdata[47:40];
        n_s0_ctx.pixel_color    = s_axis_tdata[71:48];
        n_s0_ctx.current_column = s_axis_tdata[79:72];
        n_s0_ctx.ok = ({1'b0, s_axis_tdata[47:40]} + 9'(dgc_pkg::GLYPH_H))
                      <= 9'(LED_COUNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_value <= s_axis_tdata[31:0];
            r_s0_ctx   <= n_s0_ctx;
        end
    end

    logic                c_valid  [DIGITS+1];
    logic [31:0]         c_value  [DIGITS+1];
    logic [DIGITS*4-1:0] c_digits [DIGITS+1];
    dgc_pkg::t_ctx       c_ctx    [DIGITS+1];

    assign c_valid[0]  = r_s0_valid;
    assign c_value[0]  = r_s0_value;
    assign c_digits[0] = '0;
    assign c_ctx[0]    = r_s0_ctx;

    for (genvar g = 0; g < DIGITS; g++) begin : g_div
        dgc_div10_stage #(
            .DIGITS (DIGITS),
            .IDX    (g)
        ) u_div (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (c_valid[g]),
            .i_value  (c_value[g]),
            .i_digits (c_digits[g]),
            .i_ctx    (c_ctx[g]),
            .o_valid  (c_valid[g+1]),
            .o_quot   (c_value[g+1]),
            .o_digits (c_digits[g+1]),
            .o_ctx    (c_ctx[g+1])
        );
    end

    logic        drawn;
    logic [7:0]  first_led;
    logic [5:0]  pixel_mask;
    logic [23:0] color_out;

    dgc_render #(
        .DIGITS (DIGITS),
        .GAP    (GAP)
    ) u_render (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (c_valid[DIGITS]),
        .i_quot         (c_value[DIGITS]),
        .i_digits       (c_digits[DIGITS]),
        .i_ctx          (c_ctx[DIGITS]),
        .i_column_count (r_col_count),
        .o_valid        (out_valid),
        .o_drawn        (drawn),
        .o_first_led    (first_led),
        .o_pixel_mask   (pixel_mask),
        .o_color_out    (color_out)
    );

    assign m_axis_tvalid  = out_valid;
    assign m_axis_tdata   = {1'b0, color_out, pixel_mask, first_led, drawn};

endmodule
